[sv/mrd_pkg.sv]
// Shared types, codes and constants of the MQTT receive deframer.
package mrd_pkg;

    localparam int MAX_LENGTH_BYTES = 4;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // input kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_PING    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PING_LIMIT = 2'd0;
    localparam logic [1:0] REG_HAS_SUBS   = 2'd1;

    // control packet types
    localparam logic [3:0] TYPE_CONNACK  = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_PUBREC   = 4'd5;
    localparam logic [3:0] TYPE_PUBREL   = 4'd6;
    localparam logic [3:0] TYPE_PUBCOMP  = 4'd7;
    localparam logic [3:0] TYPE_SUBACK   = 4'd9;
    localparam logic [3:0] TYPE_UNSUBACK = 4'd11;
    localparam logic [3:0] TYPE_PINGRESP = 4'd13;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_REFUSED      = 3'd1,
        ST_BAD_LENGTH   = 3'd2,
        ST_QOS          = 3'd3,
        ST_SHORT        = 3'd4,
        ST_BAD_TYPE     = 3'd5,
        ST_PING_TIMEOUT = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_PING    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  pkt_type;
        logic [27:0] packet_length;
        logic [2:0]  status;
        logic [15:0] topic_length;
        logic [7:0]  return_code;
        logic [7:0]  pending_pings;
        logic        is_connected;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] ping_limit;
        logic       has_subscriptions;
    } cfg_t;

endpackage

[sv/mrd_front.sv]
// Front end: accepts input items, classifies them and queues commands.
module mrd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mrd_pkg::in_item_t rx_item,
    output logic              cmd_valid,
    output mrd_pkg::cmd_t     cmd,
    input  logic              cmd_take
);
    import mrd_pkg::*;

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    logic accept;
    logic enq;
    cmd_t classified;

    assign full   = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign accept = push && !full;

    // drop unused kinds here so the back end never sees them
    always_comb
    begin
        classified.data_byte = rx_item.data_byte;
        enq = accept;
        unique case (rx_item.kind)
            KIND_BYTE:    classified.op = OP_BYTE;
            KIND_PING:    classified.op = OP_PING;
            KIND_RESTART: classified.op = OP_RESTART;
            default:
            begin
                classified.op = OP_BYTE;
                enq = 1'b0;
            end
        endcase
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CMD_PTR_W'(1);
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CMD_PTR_W'(1);
        end
        if (enq && !cmd_take)
        begin
            count_next = count_reg + CMD_CNT_W'(1);
        end
        else if (!enq && cmd_take)
        begin
            count_next = count_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[sv/mrd_back.sv]
// Back end: packet parser state, ping tracking and result formation.
module mrd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mrd_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    input  mrd_pkg::cmd_t      cmd,
    output logic               cmd_take,
    input  logic               res_full,
    output logic               res_push,
    output mrd_pkg::out_item_t res_item
);
    import mrd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] topic;
        logic [7:0]  rc;
        logic        conn;
        logic [7:0]  pings;
    } fin_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic [27:0] length_reg, length_next;
    logic [2:0]  seen_reg, seen_next;
    logic [27:0] count_reg, count_next;
    logic [15:0] topic_reg, topic_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  ping_reg, ping_next;
    logic        conn_reg, conn_next;

    logic [27:0] len_sum;
    logic [27:0] len_add;
    logic [2:0]  seen_inc;
    logic [27:0] count_inc;
    logic [7:0]  ping_inc;
    logic [7:0]  b;
    fin_t        fin_len;
    fin_t        fin_pay;

    function automatic fin_t finish(input logic [7:0] hdr, input logic [27:0] len,
                                    input logic [15:0] topic, input logic [7:0] code,
                                    input logic [7:0] pings, input logic conn,
                                    input logic has_subs);
        fin_t f;
        f.status = ST_OK;
        f.topic  = '0;
        f.rc     = '0;
        f.conn   = conn;
        f.pings  = pings;
        unique case (hdr[7:4])
            TYPE_CONNACK:
            begin
                if (len != 28'd2)
                begin
                    f.status = ST_BAD_LENGTH;
                end
                else
                begin
                    f.rc = code;
                    if (code != 8'd0)
                    begin
                        f.status = ST_REFUSED;
                    end
                    else if (!has_subs)
                    begin
                        f.conn = 1'b1;
                    end
                end
            end
            TYPE_PUBLISH:
            begin
                if (hdr[2:1] != 2'b00)
                begin
                    f.status = ST_QOS;
                end
                else if (len < 28'd2)
                begin
                    f.status = ST_SHORT;
                end
                else
                begin
                    f.topic = topic;
                    if ((len - 28'd2) < {12'd0, topic})
                    begin
                        f.status = ST_SHORT;
                    end
                end
            end
            TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP:
            begin
                f.status = ST_OK;
            end
            TYPE_SUBACK:
            begin
                if (len < 28'd2)
                begin
                    f.status = ST_SHORT;
                end
                else
                begin
                    f.conn = 1'b1;
                end
            end
            TYPE_UNSUBACK:
            begin
                if (len < 28'd2)
                begin
                    f.status = ST_SHORT;
                end
            end
            TYPE_PINGRESP:
            begin
                if (pings != 8'd0)
                begin
                    f.pings = pings - 8'd1;
                end
            end
            default:
            begin
                f.status = ST_BAD_TYPE;
            end
        endcase
        if (f.status != ST_OK)
        begin
            f.conn = 1'b0;
        end
        return f;
    endfunction

    assign cmd_take = cmd_valid && !res_full;
    assign b        = cmd.data_byte;

    // place the 7-bit group at its position; groups never overlap
    always_comb
    begin
        unique case (seen_reg[1:0])
            2'd0:    len_add = {21'd0, b[6:0]};
            2'd1:    len_add = {14'd0, b[6:0], 7'd0};
            2'd2:    len_add = {7'd0, b[6:0], 14'd0};
            default: len_add = {b[6:0], 21'd0};
        endcase
    end

    assign len_sum   = length_reg + len_add;
    assign seen_inc  = seen_reg + 3'd1;
    assign count_inc = count_reg + 28'd1;
    assign ping_inc  = (ping_reg == 8'hff) ? ping_reg : ping_reg + 8'd1;

    // ends during the length field see the values cleared at the header
    assign fin_len = finish(header_reg, len_sum, topic_reg, code_reg,
                            ping_reg, conn_reg, cfg.has_subscriptions);
    assign fin_pay = finish(header_reg, length_reg, topic_next, code_next,
                            ping_reg, conn_reg, cfg.has_subscriptions);

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        topic_next  = topic_reg;
        code_next   = code_reg;
        ping_next   = ping_reg;
        conn_next   = conn_reg;
        res_push    = 1'b0;
        res_item    = '0;

        if (count_reg == 28'd0)
        begin
            topic_next = {b, 8'd0};
        end
        else if (count_reg == 28'd1)
        begin
            topic_next = {topic_reg[15:8], b};
            code_next  = b;
        end

        if (cmd_take)
        begin
            unique case (cmd.op)
                OP_RESTART:
                begin
                    phase_next  = PH_HEADER;
                    header_next = '0;
                    length_next = '0;
                    seen_next   = '0;
                    count_next  = '0;
                    topic_next  = '0;
                    code_next   = '0;
                    ping_next   = '0;
                    conn_next   = 1'b0;
                end
                OP_PING:
                begin
                    topic_next = topic_reg;
                    code_next  = code_reg;
                    ping_next  = ping_inc;
                    if (ping_inc > cfg.ping_limit)
                    begin
                        conn_next              = 1'b0;
                        res_push               = 1'b1;
                        res_item.status        = ST_PING_TIMEOUT;
                        res_item.pending_pings = ping_inc;
                        res_item.is_connected  = 1'b0;
                    end
                end
                default:
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            header_next = b;
                            length_next = '0;
                            seen_next   = '0;
                            count_next  = '0;
                            topic_next  = '0;
                            code_next   = '0;
                            phase_next  = PH_LENGTH;
                        end
                        PH_LENGTH:
                        begin
                            topic_next  = topic_reg;
                            code_next   = code_reg;
                            length_next = len_sum;
                            seen_next   = seen_inc;
                            if (b[7])
                            begin
                                if (seen_inc >= 3'(MAX_LENGTH_BYTES))
                                begin
                                    conn_next              = 1'b0;
                                    phase_next             = PH_HEADER;
                                    res_push               = 1'b1;
                                    res_item.pkt_type      = header_reg[7:4];
                                    res_item.packet_length = len_sum;
                                    res_item.status        = ST_BAD_LENGTH;
                                    res_item.pending_pings = ping_reg;
                                    res_item.is_connected  = 1'b0;
                                end
                            end
                            else if (len_sum == 28'd0)
                            begin
                                phase_next             = PH_HEADER;
                                ping_next              = fin_len.pings;
                                conn_next              = fin_len.conn;
                                res_push               = 1'b1;
                                res_item.pkt_type      = header_reg[7:4];
                                res_item.packet_length = len_sum;
                                res_item.status        = fin_len.status;
                                res_item.topic_length  = fin_len.topic;
                                res_item.return_code   = fin_len.rc;
                                res_item.pending_pings = fin_len.pings;
                                res_item.is_connected  = fin_len.conn;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            count_next = count_inc;
                            if (count_inc == length_reg)
                            begin
                                phase_next             = PH_HEADER;
                                ping_next              = fin_pay.pings;
                                conn_next              = fin_pay.conn;
                                res_push               = 1'b1;
                                res_item.pkt_type      = header_reg[7:4];
                                res_item.packet_length = length_reg;
                                res_item.status        = fin_pay.status;
                                res_item.topic_length  = fin_pay.topic;
                                res_item.return_code   = fin_pay.rc;
                                res_item.pending_pings = fin_pay.pings;
                                res_item.is_connected  = fin_pay.conn;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HEADER;
                        end
                    endcase
                end
            endcase
        end
        else
        begin
            topic_next = topic_reg;
            code_next  = code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            length_reg <= '0;
            seen_reg   <= '0;
            count_reg  <= '0;
            topic_reg  <= '0;
            code_reg   <= '0;
            ping_reg   <= '0;
            conn_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            count_reg  <= count_next;
            topic_reg  <= topic_next;
            code_reg   <= code_next;
            ping_reg   <= ping_next;
            conn_reg   <= conn_next;
        end
    end

endmodule

[sv/mrd_result_queue.sv]
// Result queue: holds finished result items until the receiver pops them.
module mrd_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    input  mrd_pkg::out_item_t res_item,
    output logic               res_full,
    input  logic               pop,
    output logic               empty,
    output mrd_pkg::out_item_t report
);
    import mrd_pkg::*;

    out_item_t            mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 deq;

    assign res_full = (count_reg == RES_CNT_W'(RES_DEPTH));
    assign empty    = (count_reg == '0);
    assign deq      = pop && !empty;
    assign report   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                        : wr_ptr_reg + RES_PTR_W'(1);
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                        : rd_ptr_reg + RES_PTR_W'(1);
        end
        if (res_push && !deq)
        begin
            count_next = count_reg + RES_CNT_W'(1);
        end
        else if (!res_push && deq)
        begin
            count_next = count_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

[sv/mqtt_receive_deframer.sv]
// Top level of the MQTT receive deframer: configuration registers and wiring.
//
// Input channel: push an item (kind, data_byte) while full is low; one item can
// be taken every cycle. Kind 0 carries a received byte, kind 1 notes a ping
// request sent, kind 2 restarts the link state; other kinds are dropped.
// Result channel: while empty is low the oldest result is on report; pop takes
// it. Items are registered in the command queue, results in the result queue.
// Throughput is one item per cycle while the result queue is not full, set by
// the parser update in the back end; a two-entry command queue parts the front
// from the back and a two-entry result queue parts the back from the receiver.
// When the receiver stalls the result queue fills, the back end holds, and then
// the command queue fills and full rises; nothing is lost.
// Configuration: cfg_index 0 is ping_limit, 1 is has_subscriptions; writes are
// always taken (cfg_ready high) and other indexes are ignored. Write only while
// idle.
// Reset clears both queues and all parser state at once; ping_limit returns
// to 3 and has_subscriptions to 0. No clearing pass is needed.
module mqtt_receive_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mrd_pkg::in_item_t  rx_item,
    output logic               empty,
    input  logic               pop,
    output mrd_pkg::out_item_t report,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import mrd_pkg::*;

    cfg_t      cfg_reg;
    cmd_t      cmd;
    logic      cmd_valid;
    logic      cmd_take;
    logic      res_full;
    logic      res_push;
    out_item_t res_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ping_limit        <= 8'd3;
            cfg_reg.has_subscriptions <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_PING_LIMIT)
            begin
                cfg_reg.ping_limit <= cfg_data;
            end
            else if (cfg_index == REG_HAS_SUBS)
            begin
                cfg_reg.has_subscriptions <= cfg_data[0];
            end
        end
    end

    mrd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_item   (rx_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    mrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    mrd_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .report   (report)
    );

endmodule
